@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Each macro checks one property on the rising clock edge and is disabled
// while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge of clk, outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication with the consequent checked in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

@@ rtl/mbph_pkg.sv @@
package mbph_pkg;

	// Button count limits.
	localparam int MAX_BUTTONS = 8;
	localparam int DEFAULT_BUTTONS = 8;

	// Field widths.
	localparam int STATE_W = 3;
	localparam int COUNT_W = 8;
	localparam int LEVELS_W = 8;
	localparam int STATES_W = 24;
	localparam int LIMITS_W = 64;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 64;

	// Per-button state codes.
	localparam logic [STATE_W-1:0] ST_PRE_PUSH = 3'd0;
	localparam logic [STATE_W-1:0] ST_PUSHED = 3'd1;
	localparam logic [STATE_W-1:0] ST_PRE_HOLD = 3'd2;
	localparam logic [STATE_W-1:0] ST_HOLD = 3'd3;
	localparam logic [STATE_W-1:0] ST_PRE_RELEASE = 3'd4;
	localparam logic [STATE_W-1:0] ST_RELEASED = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LIMITS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL = 8'd1;

	// Register reset values: a limit of 20 for every button, active low.
	localparam logic [LIMITS_W-1:0] DEBOUNCE_LIMITS_RESET = 64'h1414_1414_1414_1414;
	localparam logic ACTIVE_LEVEL_RESET = 1'b0;

	// Saturating count increment.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		sat_inc = (c == {COUNT_W{1'b1}}) ? c : c + {{(COUNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

@@ rtl/multi_button_press_hold_fsm_unit.sv @@
// Press/hold state machines for up to eight buttons. Each request on the
// s_axis side carries one tick of sampled pin levels; each button steps its
// own six-state machine (pre_push, pushed, pre_hold, hold, pre_release,
// released, codes 0 to 5) and the new states of all buttons come back as one
// item on the m_axis side, three bits per button. The block takes one request
// every cycle while the result side is not stalled. A request sits in the
// input register while the state update is computed, and the update writes
// the state registers and the result register together. The rate is set by
// the update of each button's state, count and limit compare; a stalled
// result holds the input register and then stalls the input side as well.
// Configuration (per-button count limits, active pin level) is written
// through the cfg port, which is always ready; write it only while no
// request is in flight.
`include "assert_macros.svh"

module multi_button_press_hold_fsm_unit #(
	parameter int BUTTONS = mbph_pkg::DEFAULT_BUTTONS
) (
	input  logic clk,
	input  logic arst_n,

	// Tick input. tdata: pin_levels[7:0].
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [mbph_pkg::LEVELS_W-1:0] s_axis_tdata,

	// Result output. tdata: button_states[23:0].
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [mbph_pkg::STATES_W-1:0] m_axis_tdata,

	// Configuration write channel.
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mbph_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbph_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int STATE_W = mbph_pkg::STATE_W;
	localparam int COUNT_W = mbph_pkg::COUNT_W;

	logic [mbph_pkg::LIMITS_W-1:0] limits_q;
	logic active_q;

	logic valid_s1;
	logic [mbph_pkg::LEVELS_W-1:0] levels_s1;

	logic [STATE_W-1:0] state_q [BUTTONS];
	logic [COUNT_W-1:0] count_q [BUTTONS];
	logic [STATE_W-1:0] state_d [BUTTONS];
	logic [COUNT_W-1:0] count_d [BUTTONS];
	logic [mbph_pkg::STATES_W-1:0] packed_d;
	logic [mbph_pkg::STATES_W-1:0] packed_now;

	logic out_valid_q;
	logic [mbph_pkg::STATES_W-1:0] out_data_q;
	logic load_out;

	// The update fires when the input register holds a request and the result
	// register is free or being emptied this cycle.
	assign load_out = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load_out;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q <= mbph_pkg::DEBOUNCE_LIMITS_RESET;
			active_q <= mbph_pkg::ACTIVE_LEVEL_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == mbph_pkg::REG_DEBOUNCE_LIMITS) begin
				limits_q <= cfg_data;
			end else if (cfg_index == mbph_pkg::REG_ACTIVE_LEVEL) begin
				active_q <= cfg_data[0];
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			levels_s1 <= s_axis_tdata;
		end
	end

	// Next state and count of every button.
	always_comb begin
		logic m;
		logic [COUNT_W-1:0] limit;
		logic [COUNT_W-1:0] inc;
		for (int b = 0; b < BUTTONS; b++) begin
			m = (levels_s1[b] == active_q);
			limit = limits_q[8*b +: 8];
			inc = mbph_pkg::sat_inc(count_q[b]);
			state_d[b] = state_q[b];
			count_d[b] = count_q[b];
			case (state_q[b])
				mbph_pkg::ST_PRE_PUSH: begin
					if (m) begin
						state_d[b] = mbph_pkg::ST_PUSHED;
					end
				end
				mbph_pkg::ST_PUSHED: begin
					state_d[b] = m ? mbph_pkg::ST_PRE_HOLD : mbph_pkg::ST_RELEASED;
				end
				mbph_pkg::ST_PRE_HOLD: begin
					state_d[b] = m ? mbph_pkg::ST_HOLD : mbph_pkg::ST_RELEASED;
				end
				mbph_pkg::ST_HOLD: begin
					if (m) begin
						if (inc >= limit) begin
							count_d[b] = '0;
							state_d[b] = mbph_pkg::ST_PRE_RELEASE;
						end else begin
							count_d[b] = inc;
						end
					end
				end
				mbph_pkg::ST_PRE_RELEASE: begin
					if (m) begin
						count_d[b] = inc;
					end else begin
						state_d[b] = (count_q[b] >= limit) ? mbph_pkg::ST_RELEASED
							: mbph_pkg::ST_PRE_PUSH;
						count_d[b] = '0;
					end
				end
				mbph_pkg::ST_RELEASED: begin
					if (!m) begin
						state_d[b] = mbph_pkg::ST_PRE_PUSH;
					end
				end
				default: begin
					state_d[b] = state_q[b];
				end
			endcase
		end
	end

	// Pack the new and the current states; unused button slots read as zero.
	always_comb begin
		packed_d = '0;
		packed_now = '0;
		for (int b = 0; b < BUTTONS; b++) begin
			packed_d[3*b +: 3] = state_d[b];
			packed_now[3*b +: 3] = state_q[b];
		end
	end

	// Button state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BUTTONS; b++) begin
				state_q[b] <= mbph_pkg::ST_PRE_PUSH;
				count_q[b] <= '0;
			end
		end else if (load_out) begin
			for (int b = 0; b < BUTTONS; b++) begin
				state_q[b] <= state_d[b];
				count_q[b] <= count_d[b];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= packed_d;
		end
	end

	// A stalled result with a full input register must hold off new requests.
	`ASSERT_CLK(a_stall_blocks_input, clk, arst_n, !(valid_s1 && out_valid_q && !m_axis_tready && s_axis_tready), "input accepted while both stages are stalled")

	// The result just loaded reflects the state registers written with it.
	`ASSERT_NEXT(a_result_matches_state, clk, arst_n, load_out, m_axis_tdata == packed_now, "result differs from updated button states")

	// A fresh result never appears without a request in the input register.
	`ASSERT_NEXT(a_result_needs_request, clk, arst_n, !valid_s1 && !out_valid_q, !m_axis_tvalid, "result produced with no request")

	// The count is only ever nonzero while holding or waiting for release.
	for (genvar g = 0; g < BUTTONS; g++) begin : g_count_chk
		`ASSERT_CLK(a_count_idle_zero, clk, arst_n, (count_q[g] == '0) || (state_q[g] == mbph_pkg::ST_HOLD) || (state_q[g] == mbph_pkg::ST_PRE_RELEASE), "count nonzero outside hold states")
	end

endmodule
